@@ hdl/spvg_pkg.sv @@
// ----------------------------------------------------------------------------
// spvg_pkg
// Shared widths, defaults, control struct and the sine table builder for the
// sector polygon vertex generator.
// ----------------------------------------------------------------------------
package spvg_pkg;

  // Field widths
  localparam int unsigned COORD_W    = 16;  // Q11.4 coordinates
  localparam int unsigned IDX_W      = 9;   // vertex index
  localparam int unsigned ANGLE_W    = 9;   // sector angle register
  localparam int unsigned DIFF_W     = 17;  // end - center, exact
  localparam int unsigned HDEG_W     = 10;  // half-degree angle 0..719

  // Sector angle limits and defaults
  localparam int unsigned MIN_SECTOR_DEG     = 5;
  localparam int unsigned SECTOR_RESET       = 60;
  localparam int unsigned MAX_SECTOR_DEG_DEF = 360;
  localparam int unsigned TRIG_FRAC_BITS_DEF = 15;

  // First-quadrant sine table, half-degree steps
  localparam int unsigned SINE_TAB_LEN = 181;
  localparam int unsigned SINE_TAB_AW  = 8;
  localparam int unsigned SINE_TAB_W   = 31;  // widest entry: 1.0 at 30 frac bits

  typedef logic [SINE_TAB_W-1:0] sine_tab_t [SINE_TAB_LEN];

  // Control that travels with each item down the pipeline
  typedef struct packed {
    logic valid;
    logic last;
    logic oor;
  } spvg_ctl_t;

  // pi in Q60 and one half-degree step in Q60
  localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
  localparam logic [63:0] STEP_Q60 = PI_Q60 / 64'd360;

  // sin(i * 0.5 deg) in Q30, alternating Taylor series, truncated each step
  function automatic logic signed [63:0] sine_q30(input int unsigned i);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (STEP_Q60 * 64'(i)) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed(term);
    term = ((term * x2) >> 30) / 64'd342; sum = sum - $signed(term);
    term = ((term * x2) >> 30) / 64'd420; sum = sum + $signed(term);
    return sum;
  endfunction

  // Whole table, rounded half up to frac_bits fraction bits
  function automatic sine_tab_t build_sine_tab(input int unsigned frac_bits);
    sine_tab_t          tab;
    logic signed [63:0] v;
    for (int unsigned i = 0; i < SINE_TAB_LEN; i++) begin
      v = sine_q30(i);
      if (frac_bits < 30) begin
        v = (v + (64'sd1 <<< (29 - frac_bits))) >>> (30 - frac_bits);
      end
      tab[i] = v[SINE_TAB_W-1:0];
    end
    return tab;
  endfunction

endpackage

@@ hdl/spvg_ifs.sv @@
// ----------------------------------------------------------------------------
// spvg_ifs
// Valid/ready channels for vertex requests and vertex results.
// ----------------------------------------------------------------------------
interface spvg_req_if;
  import spvg_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  logic [IDX_W-1:0]          vertex_index;

  modport source (output valid, center_x, center_y, end_x, end_y, vertex_index,
                  input ready);
  modport sink   (input valid, center_x, center_y, end_x, end_y, vertex_index,
                  output ready);
endinterface

interface spvg_vert_if;
  import spvg_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] vert_x;
  logic signed [COORD_W-1:0] vert_y;
  logic                      last_vertex;
  logic                      out_of_range;

  modport source (output valid, vert_x, vert_y, last_vertex, out_of_range,
                  input ready);
  modport sink   (input valid, vert_x, vert_y, last_vertex, out_of_range,
                  output ready);
endinterface

@@ hdl/spvg_front.sv @@
// ----------------------------------------------------------------------------
// spvg_front
// Stage 1: classifies the index, forms the axis vector and the half-degree
// angles for sine and cosine.
// ----------------------------------------------------------------------------
module spvg_front
  import spvg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic signed [COORD_W-1:0] center_x,
  input  logic signed [COORD_W-1:0] center_y,
  input  logic signed [COORD_W-1:0] end_x,
  input  logic signed [COORD_W-1:0] end_y,
  input  logic [IDX_W-1:0]          vertex_index,
  input  logic [ANGLE_W-1:0]        open_deg,
  output spvg_ctl_t                 ctl,
  output logic signed [COORD_W-1:0] cx,
  output logic signed [COORD_W-1:0] cy,
  output logic signed [DIFF_W-1:0]  dx,
  output logic signed [DIFF_W-1:0]  dy,
  output logic [HDEG_W-1:0]         sin_h,
  output logic [HDEG_W-1:0]         cos_h
);

  logic [ANGLE_W:0]   n_plus1;
  logic [IDX_W:0]     idx_ext;
  logic signed [11:0] h;
  logic [HDEG_W:0]    hm;
  logic [HDEG_W:0]    cm;
  spvg_ctl_t          ctl_next;

  // index class and rotation angle
  always_comb begin
    n_plus1 = {1'b0, open_deg} + (ANGLE_W+1)'(1);
    idx_ext = {1'b0, vertex_index};
    ctl_next.valid = in_valid;
    ctl_next.oor   = (idx_ext > n_plus1);
    ctl_next.last  = (idx_ext == n_plus1);
    if (vertex_index == '0) begin
      h = $signed({3'b000, open_deg});
    end else begin
      h = $signed({3'b000, open_deg})
        - $signed({2'b00, vertex_index - IDX_W'(1), 1'b0});
    end
    // wrap into 0..719, then cosine is a quarter turn ahead
    if (h < 0) begin
      hm = 11'(h + 12'sd720);
    end else begin
      hm = 11'(h);
    end
    cm = hm + 11'd180;
    if (cm >= 11'd720) begin
      cm = cm - 11'd720;
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_next;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (en) begin
      cx    <= center_x;
      cy    <= center_y;
      dx    <= DIFF_W'(end_x) - DIFF_W'(center_x);
      dy    <= DIFF_W'(end_y) - DIFF_W'(center_y);
      sin_h <= hm[HDEG_W-1:0];
      cos_h <= cm[HDEG_W-1:0];
    end
  end

endmodule

@@ hdl/spvg_trig.sv @@
// ----------------------------------------------------------------------------
// spvg_trig
// Stage 2: sine and cosine lookup from the quarter-wave table.
// ----------------------------------------------------------------------------
module spvg_trig
  import spvg_pkg::*;
#(
  parameter int unsigned TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  spvg_ctl_t                      ctl_in,
  input  logic signed [COORD_W-1:0]      cx_in,
  input  logic signed [COORD_W-1:0]      cy_in,
  input  logic signed [DIFF_W-1:0]       dx_in,
  input  logic signed [DIFF_W-1:0]       dy_in,
  input  logic [HDEG_W-1:0]              sin_h,
  input  logic [HDEG_W-1:0]              cos_h,
  output spvg_ctl_t                      ctl,
  output logic signed [COORD_W-1:0]      cx,
  output logic signed [COORD_W-1:0]      cy,
  output logic signed [DIFF_W-1:0]       dx,
  output logic signed [DIFF_W-1:0]       dy,
  output logic signed [TRIG_FRAC_BITS+1:0] sin_v,
  output logic signed [TRIG_FRAC_BITS+1:0] cos_v
);

  localparam int unsigned TRIG_W = TRIG_FRAC_BITS + 2;
  localparam sine_tab_t   SINE_TAB = build_sine_tab(TRIG_FRAC_BITS);

  // signed sine of a half-degree angle by quadrant symmetry
  function automatic logic signed [TRIG_W-1:0] sine_half(input logic [HDEG_W-1:0] hh);
    logic [SINE_TAB_AW-1:0] a;
    logic                   neg;
    logic [TRIG_W-1:0]      mag;
    neg = 1'b0;
    if (hh <= 10'd180) begin
      a = SINE_TAB_AW'(hh);
    end else if (hh <= 10'd360) begin
      a = SINE_TAB_AW'(10'd360 - hh);
    end else if (hh <= 10'd540) begin
      a   = SINE_TAB_AW'(hh - 10'd360);
      neg = 1'b1;
    end else if (hh < 10'd720) begin
      a   = SINE_TAB_AW'(10'd720 - hh);
      neg = 1'b1;
    end else begin
      a = '0;
    end
    mag = {1'b0, SINE_TAB[a][TRIG_FRAC_BITS:0]};
    return neg ? $signed(-mag) : $signed(mag);
  endfunction

  // control register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_in;
    end
  end

  // payload register
  always_ff @(posedge clk) begin
    if (en) begin
      cx    <= cx_in;
      cy    <= cy_in;
      dx    <= dx_in;
      dy    <= dy_in;
      sin_v <= sine_half(sin_h);
      cos_v <= sine_half(cos_h);
    end
  end

endmodule

@@ hdl/spvg_rot.sv @@
// ----------------------------------------------------------------------------
// spvg_rot
// Stages 3 to 5: rotation products, sum and round to Q11.4, then center
// offset and saturation into the output register.
// ----------------------------------------------------------------------------
module spvg_rot
  import spvg_pkg::*;
#(
  parameter int unsigned TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  spvg_ctl_t                        ctl_in,
  input  logic signed [COORD_W-1:0]        cx_in,
  input  logic signed [COORD_W-1:0]        cy_in,
  input  logic signed [DIFF_W-1:0]         dx_in,
  input  logic signed [DIFF_W-1:0]         dy_in,
  input  logic signed [TRIG_FRAC_BITS+1:0] sin_v,
  input  logic signed [TRIG_FRAC_BITS+1:0] cos_v,
  output logic                             out_valid,
  output logic signed [COORD_W-1:0]        vert_x,
  output logic signed [COORD_W-1:0]        vert_y,
  output logic                             last_vertex,
  output logic                             out_of_range
);

  localparam int unsigned TRIG_W = TRIG_FRAC_BITS + 2;
  localparam int unsigned PROD_W = DIFF_W + TRIG_W;
  localparam int unsigned SUM_W  = PROD_W + 1;
  localparam int unsigned RND_W  = SUM_W - TRIG_FRAC_BITS;
  localparam int unsigned OFS_W  = RND_W + 1;
  localparam logic signed [SUM_W-1:0] HALF =
    {{(SUM_W-1){1'b0}}, 1'b1} << (TRIG_FRAC_BITS - 1);

  // stage 3: products
  spvg_ctl_t                 ctl3;
  logic signed [COORD_W-1:0] cx3, cy3;
  logic signed [PROD_W-1:0]  pxc, pys, pxs, pyc;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl3 <= '0;
    end else if (en) begin
      ctl3 <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx3 <= cx_in;
      cy3 <= cy_in;
      pxc <= dx_in * cos_v;
      pys <= dy_in * sin_v;
      pxs <= dx_in * sin_v;
      pyc <= dy_in * cos_v;
    end
  end

  // stage 4: rotate and round half up
  spvg_ctl_t                 ctl4;
  logic signed [COORD_W-1:0] cx4, cy4;
  logic signed [RND_W-1:0]   rx, ry;
  logic signed [SUM_W-1:0]   sum_x, sum_y, rnd_x, rnd_y;

  always_comb begin
    sum_x = SUM_W'(pxc) - SUM_W'(pys);
    sum_y = SUM_W'(pxs) + SUM_W'(pyc);
    rnd_x = (sum_x + HALF) >>> TRIG_FRAC_BITS;
    rnd_y = (sum_y + HALF) >>> TRIG_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl4 <= '0;
    end else if (en) begin
      ctl4 <= ctl3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx4 <= cx3;
      cy4 <= cy3;
      rx  <= rnd_x[RND_W-1:0];
      ry  <= rnd_y[RND_W-1:0];
    end
  end

  // stage 5: add center, saturate, select by index class
  logic signed [OFS_W-1:0]   ofs_x, ofs_y;
  logic signed [COORD_W-1:0] sat_x, sat_y, vx_next, vy_next;

  function automatic logic signed [COORD_W-1:0] sat16(input logic signed [OFS_W-1:0] v);
    if (v[OFS_W-1:COORD_W-1] == '0 || v[OFS_W-1:COORD_W-1] == '1) begin
      return v[COORD_W-1:0];
    end else if (v[OFS_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  always_comb begin
    ofs_x = OFS_W'(cx4) + OFS_W'(rx);
    ofs_y = OFS_W'(cy4) + OFS_W'(ry);
    sat_x = sat16(ofs_x);
    sat_y = sat16(ofs_y);
    priority if (ctl4.oor) begin
      vx_next = '0;
      vy_next = '0;
    end else if (ctl4.last) begin
      vx_next = cx4;
      vy_next = cy4;
    end else begin
      vx_next = sat_x;
      vy_next = sat_y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctl4.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vert_x       <= vx_next;
      vert_y       <= vy_next;
      last_vertex  <= ctl4.last & ~ctl4.oor;
      out_of_range <= ctl4.oor;
    end
  end

endmodule

@@ hdl/sector_polygon_vertex_gen.sv @@
// Sector polygon vertex generator. Each request (center, axis end point,
// vertex index) returns one vertex of a polygon approximating a circular
// sector whose opening angle is the configured number of degrees (clamped to
// 5..MAX_SECTOR_DEG on write): index 0 and 1 lie at +angle/2, each further
// index steps one degree clockwise, index angle+1 is the center (last_vertex),
// and higher indexes return zeros with out_of_range. One request is accepted
// per clock while the pipeline is not held; the result is presented
// through five register stages: decode, table lookup, multiply, round, and
// center add with saturation. The whole pipeline holds while the output is
// not taken. Write the opening angle only while no request is in flight.
// ----------------------------------------------------------------------------
// sector_polygon_vertex_gen
// Top level: angle register, pipeline enable and stage wiring.
// ----------------------------------------------------------------------------
module sector_polygon_vertex_gen
  import spvg_pkg::*;
#(
  parameter int unsigned TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
  parameter int unsigned MAX_SECTOR_DEG = MAX_SECTOR_DEG_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [ANGLE_W-1:0] cfg_wr_data,
  spvg_req_if.sink           in_ch,
  spvg_vert_if.source        out_ch
);

  localparam int unsigned TRIG_W = TRIG_FRAC_BITS + 2;

  logic [ANGLE_W-1:0] open_deg;
  logic               en;

  // sector angle register with clamp
  always_ff @(posedge clk) begin
    if (rst) begin
      open_deg <= ANGLE_W'(SECTOR_RESET);
    end else if (cfg_wr_en) begin
      priority if (cfg_wr_data < ANGLE_W'(MIN_SECTOR_DEG)) begin
        open_deg <= ANGLE_W'(MIN_SECTOR_DEG);
      end else if (cfg_wr_data >= ANGLE_W'(MAX_SECTOR_DEG)) begin
        open_deg <= ANGLE_W'(MAX_SECTOR_DEG);
      end else begin
        open_deg <= cfg_wr_data;
      end
    end
  end

  // whole pipeline advances unless a finished item is waiting
  assign en           = ~out_ch.valid | out_ch.ready;
  assign in_ch.ready  = en;

  spvg_ctl_t                 ctl1, ctl2;
  logic signed [COORD_W-1:0] cx1, cy1, cx2, cy2;
  logic signed [DIFF_W-1:0]  dx1, dy1, dx2, dy2;
  logic [HDEG_W-1:0]         sin_h, cos_h;
  logic signed [TRIG_W-1:0]  sin_v, cos_v;

  spvg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (in_ch.valid),
    .center_x     (in_ch.center_x),
    .center_y     (in_ch.center_y),
    .end_x        (in_ch.end_x),
    .end_y        (in_ch.end_y),
    .vertex_index (in_ch.vertex_index),
    .open_deg     (open_deg),
    .ctl          (ctl1),
    .cx           (cx1),
    .cy           (cy1),
    .dx           (dx1),
    .dy           (dy1),
    .sin_h        (sin_h),
    .cos_h        (cos_h)
  );

  spvg_trig #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .ctl_in (ctl1),
    .cx_in  (cx1),
    .cy_in  (cy1),
    .dx_in  (dx1),
    .dy_in  (dy1),
    .sin_h  (sin_h),
    .cos_h  (cos_h),
    .ctl    (ctl2),
    .cx     (cx2),
    .cy     (cy2),
    .dx     (dx2),
    .dy     (dy2),
    .sin_v  (sin_v),
    .cos_v  (cos_v)
  );

  spvg_rot #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rot (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .ctl_in       (ctl2),
    .cx_in        (cx2),
    .cy_in        (cy2),
    .dx_in        (dx2),
    .dy_in        (dy2),
    .sin_v        (sin_v),
    .cos_v        (cos_v),
    .out_valid    (out_ch.valid),
    .vert_x       (out_ch.vert_x),
    .vert_y       (out_ch.vert_y),
    .last_vertex  (out_ch.last_vertex),
    .out_of_range (out_ch.out_of_range)
  );

endmodule
